/* hdl/hsv2rgb_pkg.sv */
// shared types, constants and sector decode for the hsv to rgb converter
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

  localparam int FRACTION_BITS_DEF = 10;
  localparam int HUE_W  = 9;
  localparam int DIST_W = 6;
  localparam int CHAN_W = 8;

  localparam logic [DIST_W-1:0] SECTOR_SPAN = DIST_W'(60);

  typedef enum logic [2:0] {
    SEC_R_TO_Y,
    SEC_Y_TO_G,
    SEC_G_TO_C,
    SEC_C_TO_B,
    SEC_B_TO_M,
    SEC_M_TO_R
  } sector_t;

  // what a channel carries on top of the offset m
  typedef enum logic [1:0] {
    SEL_FULL,
    SEL_X,
    SEL_ZERO
  } sel_t;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  function automatic sel_t chan_sel(sector_t sec, chan_t ch);
    sel_t r;
    sel_t g;
    sel_t b;
    sel_t res;
    unique case (sec)
      SEC_R_TO_Y: begin r = SEL_FULL; g = SEL_X;    b = SEL_ZERO; end
      SEC_Y_TO_G: begin r = SEL_X;    g = SEL_FULL; b = SEL_ZERO; end
      SEC_G_TO_C: begin r = SEL_ZERO; g = SEL_FULL; b = SEL_X;    end
      SEC_C_TO_B: begin r = SEL_ZERO; g = SEL_X;    b = SEL_FULL; end
      SEC_B_TO_M: begin r = SEL_X;    g = SEL_ZERO; b = SEL_FULL; end
      default: begin r = SEL_FULL; g = SEL_ZERO; b = SEL_X; end
    endcase
    unique case (ch)
      CH_RED:   res = r;
      CH_GREEN: res = g;
      default:  res = b;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* hdl/hsv_to_rgb_converter.sv */
// pipeline: 4 stages from an input transfer to the result valid at the output
// throughput: one pixel per cycle unless stalled; a stall holds only full stages
// stages: sector decode, channel weight, weight times value, scale and clamp
// reset: clears the stage valid bits only; the datapath registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   pixel_valid,
  output logic                        pixel_ready,
  input  wire logic [HUE_W-1:0]       hue,
  input  wire logic [FRACTION_BITS:0] saturation,
  input  wire logic [FRACTION_BITS:0] brightness,
  output logic                        rgb_valid,
  input  wire logic                   rgb_ready,
  output logic [CHAN_W-1:0]           red,
  output logic [CHAN_W-1:0]           green,
  output logic [CHAN_W-1:0]           blue
);

  logic                   vld1;
  logic                   vld2;
  logic                   vld3;
  logic                   vld4;
  stage_en_t              en;
  sector_t                sector;
  logic [DIST_W-1:0]      hue_gap;
  logic [FRACTION_BITS:0] sat;
  logic [FRACTION_BITS:0] val;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en.s4 = !vld4 || rgb_ready;
    en.s3 = !vld3 || en.s4;
    en.s2 = !vld2 || en.s3;
    en.s1 = !vld1 || en.s2;
  end

  assign pixel_ready = en.s1;
  assign rgb_valid   = vld4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
    end else begin
      if (en.s1) begin
        vld1 <= pixel_valid;
      end
      if (en.s2) begin
        vld2 <= vld1;
      end
      if (en.s3) begin
        vld3 <= vld2;
      end
      if (en.s4) begin
        vld4 <= vld3;
      end
    end
  end

  hsv2rgb_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk        (clk),
    .en         (en),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .sector     (sector),
    .hue_gap    (hue_gap),
    .sat        (sat),
    .val        (val)
  );

  hsv2rgb_lane #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_lane_red (
    .clk     (clk),
    .en      (en),
    .sel     (chan_sel(sector, CH_RED)),
    .hue_gap (hue_gap),
    .sat     (sat),
    .val     (val),
    .chan    (red)
  );

  hsv2rgb_lane #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_lane_green (
    .clk     (clk),
    .en      (en),
    .sel     (chan_sel(sector, CH_GREEN)),
    .hue_gap (hue_gap),
    .sat     (sat),
    .val     (val),
    .chan    (green)
  );

  hsv2rgb_lane #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_lane_blue (
    .clk     (clk),
    .en      (en),
    .sel     (chan_sel(sector, CH_BLUE)),
    .hue_gap (hue_gap),
    .sat     (sat),
    .val     (val),
    .chan    (blue)
  );

  // an empty output stage never blocks the input
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !rgb_valid |-> pixel_ready)
    else $error("input stalled while output stage empty");

  // a full stage that advances hands its item on
  a_stage3_moves: assert property (@(posedge clk) disable iff (rst)
    vld3 && en.s4 |=> vld4)
    else $error("item lost between product and output stage");

  // an input transfer fills the first stage
  a_input_lands: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready |=> vld1)
    else $error("accepted pixel missing from first stage");

endmodule

`default_nettype wire

/* hdl/hsv2rgb_front.sv */
// first stage: hue sector and distance of hue mod 120 from 60
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_front
  import hsv2rgb_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire stage_en_t                en,
  input  wire logic [HUE_W-1:0]         hue,
  input  wire logic [FRACTION_BITS:0]   saturation,
  input  wire logic [FRACTION_BITS:0]   brightness,
  output sector_t                       sector,
  output logic [DIST_W-1:0]             hue_gap,
  output logic [FRACTION_BITS:0]        sat,
  output logic [FRACTION_BITS:0]        val
);

  localparam logic [HUE_W-1:0] H60  = HUE_W'(60);
  localparam logic [HUE_W-1:0] H120 = HUE_W'(120);
  localparam logic [HUE_W-1:0] H180 = HUE_W'(180);
  localparam logic [HUE_W-1:0] H240 = HUE_W'(240);
  localparam logic [HUE_W-1:0] H300 = HUE_W'(300);
  localparam logic [HUE_W-1:0] H360 = HUE_W'(360);
  localparam logic [HUE_W-1:0] H480 = HUE_W'(480);

  logic [HUE_W-1:0]  hue_off;
  logic [HUE_W-1:0]  hue_mod;
  logic [6:0]        hm;
  logic [DIST_W-1:0] hue_gap_next;
  sector_t           sector_next;

  always_comb begin
    if (hue >= H480) begin
      hue_off = H480;
    end else if (hue >= H360) begin
      hue_off = H360;
    end else if (hue >= H240) begin
      hue_off = H240;
    end else if (hue >= H120) begin
      hue_off = H120;
    end else begin
      hue_off = '0;
    end
    hue_mod = hue - hue_off;
    hm      = hue_mod[6:0];
    if (hm >= 7'(SECTOR_SPAN)) begin
      hue_gap_next = DIST_W'(hm - 7'(SECTOR_SPAN));
    end else begin
      hue_gap_next = DIST_W'(7'(SECTOR_SPAN) - hm);
    end

    // hue at 360 and above stays in the last sector
    if (hue < H60) begin
      sector_next = SEC_R_TO_Y;
    end else if (hue < H120) begin
      sector_next = SEC_Y_TO_G;
    end else if (hue < H180) begin
      sector_next = SEC_G_TO_C;
    end else if (hue < H240) begin
      sector_next = SEC_C_TO_B;
    end else if (hue < H300) begin
      sector_next = SEC_B_TO_M;
    end else begin
      sector_next = SEC_M_TO_R;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      sector  <= sector_next;
      hue_gap <= hue_gap_next;
      sat     <= saturation;
      val     <= brightness;
    end
  end

endmodule

`default_nettype wire

/* hdl/hsv2rgb_lane.sv */
// one color channel: weight, product with value, scale by 255 and clamp
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_lane
  import hsv2rgb_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire stage_en_t              en,
  input  wire sel_t                   sel,
  input  wire logic [DIST_W-1:0]      hue_gap,
  input  wire logic [FRACTION_BITS:0] sat,
  input  wire logic [FRACTION_BITS:0] val,
  output logic [CHAN_W-1:0]           chan
);

  localparam int SV_W   = FRACTION_BITS + 1;
  localparam int DS_W   = DIST_W + SV_W;
  localparam int K_W    = FRACTION_BITS + 8;
  localparam int KP_W   = FRACTION_BITS + 6;
  localparam int MUL_W  = KP_W + SV_W;
  localparam int SC_W   = MUL_W + 5;
  localparam int SHIFT  = 2 * FRACTION_BITS + 2;
  localparam int TOP_W  = SC_W - SHIFT;

  logic [DIST_W-1:0]      d;
  logic [DS_W-1:0]        ds;
  logic signed [K_W-1:0]  k;
  logic [KP_W-1:0]        kpos;
  logic [SV_W-1:0]        val2;
  logic [MUL_W-1:0]       mul;
  logic [SC_W-1:0]        scaled;
  logic [TOP_W-1:0]       top;

  // channel + m = val * (60*one - d*sat), with d = 60 - triangle weight
  always_comb begin
    case (sel)
      SEL_FULL: d = '0;
      SEL_X:    d = hue_gap;
      default:  d = SECTOR_SPAN;
    endcase
  end

  assign ds = DS_W'(d) * DS_W'(sat);
  assign k  = $signed(K_W'(60) << FRACTION_BITS) - $signed(K_W'(ds));

  always_ff @(posedge clk) begin
    if (en.s2) begin
      kpos <= (k > 0) ? k[KP_W-1:0] : '0;
      val2 <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      mul <= MUL_W'(kpos) * MUL_W'(val2);
    end
  end

  // 255/60 = 17/4, so the divide is times 17 then a shift
  assign scaled = (SC_W'(mul) << 4) + SC_W'(mul);
  assign top    = scaled[SC_W-1:SHIFT];

  always_ff @(posedge clk) begin
    if (en.s4) begin
      chan <= (|top[TOP_W-1:CHAN_W]) ? {CHAN_W{1'b1}} : top[CHAN_W-1:0];
    end
  end

endmodule

`default_nettype wire
